// File: rtl/core/iotbs_pkg.sv
// ----------------------------------------------------------------------------
// iotbs_pkg
// Shared constants, codes and types of the token bucket shaper.
// ----------------------------------------------------------------------------
package iotbs_pkg;

    localparam int QUEUE_DEPTH    = 16;
    localparam int REFILL_DIVISOR = 100;
    localparam int TAG_BITS       = 8;
    localparam int MAX_RESULTS    = 16;

    localparam int LEN_W  = 32;
    localparam int RATE_W = 32;

    // deferred queue addressing
    localparam int QA_W = $clog2(QUEUE_DEPTH);
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int RC_W = $clog2(MAX_RESULTS + 1);

    // front queue between intake and execution
    localparam int FQ_DEPTH = 2;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);
    localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

    // item kinds
    localparam logic KIND_REQ  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // verdict codes
    localparam logic [1:0] VERDICT_GRANTED  = 2'd0;
    localparam logic [1:0] VERDICT_DEFERRED = 2'd1;
    localparam logic [1:0] VERDICT_RELEASED = 2'd2;
    localparam logic [1:0] VERDICT_REFUSED  = 2'd3;

    typedef struct packed {
        logic                kind;
        logic [LEN_W-1:0]    len;
        logic [TAG_BITS-1:0] tag;
    } t_item;

endpackage

// File: rtl/core/iotbs_front.sv
// ----------------------------------------------------------------------------
// iotbs_front
// Intake side: takes request and tick words and holds them in a short queue
// for the execution side.
// ----------------------------------------------------------------------------
module iotbs_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  iotbs_pkg::t_item    i_item,
    output logic                o_item_valid,
    output iotbs_pkg::t_item    o_item,
    input  logic                i_pop
);
    import iotbs_pkg::*;

    t_item              r_item [FQ_DEPTH];
    logic [FQ_AW-1:0]   r_wp, n_wp;
    logic [FQ_AW-1:0]   r_rp, n_rp;
    logic [FQ_CW-1:0]   r_cnt, n_cnt;
    logic               push;
    logic               pop;

    function automatic logic [FQ_AW-1:0] ptr_inc(input logic [FQ_AW-1:0] p);
        ptr_inc = (p == FQ_AW'(FQ_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_in_stall   = (r_cnt == FQ_CW'(FQ_DEPTH));
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_item[r_rp];

    assign push = i_in_valid && !o_in_stall;
    assign pop  = i_pop && o_item_valid;

    always_comb begin
        n_wp  = push ? ptr_inc(r_wp) : r_wp;
        n_rp  = pop ? ptr_inc(r_rp) : r_rp;
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_item[r_wp] <= i_item;
        end
    end

endmodule

// File: rtl/core/iotbs_div.sv
// ----------------------------------------------------------------------------
// iotbs_div
// Refill amount: rate over the refill divisor by reciprocal multiplication,
// registered at each rate write.
// ----------------------------------------------------------------------------
module iotbs_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [iotbs_pkg::RATE_W-1:0]     i_dividend,
    output logic [iotbs_pkg::RATE_W-1:0]     o_quotient
);
    import iotbs_pkg::*;

    localparam int PROD_W    = 2 * RATE_W + 1;
    // round-up reciprocal, exact for every 32-bit dividend
    localparam int DIV_SHIFT = RATE_W + $clog2(REFILL_DIVISOR);
    localparam logic [PROD_W-1:0] DIV_MAGIC =
        PROD_W'(((PROD_W'(1) << DIV_SHIFT) + PROD_W'(REFILL_DIVISOR - 1))
                / PROD_W'(REFILL_DIVISOR));

    logic [RATE_W-1:0]  r_quo, n_quo;
    logic [PROD_W-1:0]  prod;

    assign prod  = PROD_W'(i_dividend) * DIV_MAGIC;
    assign n_quo = i_start ? RATE_W'(prod >> DIV_SHIFT) : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quo <= '0;
        end else begin
            r_quo <= n_quo;
        end
    end

    assign o_quotient = r_quo;

endmodule

// File: rtl/core/iotbs_back.sv
// ----------------------------------------------------------------------------
// iotbs_back
// Execution side: token bucket, deferred request queue, drain sequencer and
// output register.
// ----------------------------------------------------------------------------
module iotbs_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [iotbs_pkg::RATE_W-1:0]     i_cfg_data,
    input  logic                             i_item_valid,
    input  iotbs_pkg::t_item                 i_item,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [iotbs_pkg::TAG_BITS-1:0]   o_tag,
    output logic [iotbs_pkg::LEN_W-1:0]      o_length,
    output logic [1:0]                       o_verdict,
    output logic                             o_last
);
    import iotbs_pkg::*;

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;
    localparam int   SUM_W    = QC_W + 1;

    logic                   r_state, n_state;
    logic [RATE_W-1:0]      r_rate, n_rate;
    logic [RATE_W-1:0]      r_bal, n_bal;
    logic [QA_W-1:0]        r_head, n_head;
    logic [QC_W-1:0]        r_count, n_count;
    logic [RC_W-1:0]        r_nrel, n_nrel;

    logic                   r_pend_valid, n_pend_valid;
    logic [LEN_W-1:0]       r_pend_len, n_pend_len;
    logic [TAG_BITS-1:0]    r_pend_tag, n_pend_tag;

    logic                   r_out_valid, n_out_valid;
    logic [TAG_BITS-1:0]    r_out_tag, n_out_tag;
    logic [LEN_W-1:0]       r_out_len, n_out_len;
    logic [1:0]             r_out_verdict, n_out_verdict;
    logic                   r_out_last, n_out_last;

    logic [LEN_W-1:0]       mem_len [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]    mem_tag [QUEUE_DEPTH];
    logic [LEN_W-1:0]       r_rd_len;
    logic [TAG_BITS-1:0]    r_rd_tag;
    logic                   mem_we;

    logic [RATE_W-1:0]      quotient;
    logic [RATE_W-1:0]      refill;
    logic [RATE_W:0]        bal_sum;
    logic [SUM_W-1:0]       tail_sum;
    logic [QA_W-1:0]        tail;
    logic [QA_W-1:0]        head_inc;
    logic                   out_free;
    logic                   head_fits;

    iotbs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cfg_valid),
        .i_dividend (i_cfg_data),
        .o_quotient (quotient)
    );

    assign refill   = (quotient == '0) ? RATE_W'(1) : quotient;
    assign bal_sum  = {1'b0, r_bal} + {1'b0, refill};
    assign tail_sum = SUM_W'(r_head) + SUM_W'(r_count);
    assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                    ? QA_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : QA_W'(tail_sum);
    assign head_inc = (r_head == QA_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign out_free = !r_out_valid || !i_out_stall;
    assign head_fits = (r_count != '0) && (r_nrel < RC_W'(MAX_RESULTS))
                     && (r_bal >= r_rd_len);

    always_comb begin
        n_state       = r_state;
        n_rate        = r_rate;
        n_bal         = r_bal;
        n_head        = r_head;
        n_count       = r_count;
        n_nrel        = r_nrel;
        n_pend_valid  = r_pend_valid;
        n_pend_len    = r_pend_len;
        n_pend_tag    = r_pend_tag;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_tag     = r_out_tag;
        n_out_len     = r_out_len;
        n_out_verdict = r_out_verdict;
        n_out_last    = r_out_last;
        mem_we        = 1'b0;
        o_pop         = 1'b0;

        if (i_cfg_valid) begin
            n_rate = i_cfg_data;
            n_bal  = i_cfg_data;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid && out_free && !i_cfg_valid) begin
                    o_pop = 1'b1;
                    if (i_item.kind == KIND_REQ) begin
                        n_out_valid = 1'b1;
                        n_out_tag   = i_item.tag;
                        n_out_len   = i_item.len;
                        n_out_last  = 1'b1;
                        priority if (r_rate == '0) begin
                            n_out_verdict = VERDICT_GRANTED;
                        end else if (r_bal >= i_item.len) begin
                            n_bal         = r_bal - i_item.len;
                            n_out_verdict = VERDICT_GRANTED;
                        end else if (r_count < QC_W'(QUEUE_DEPTH)) begin
                            mem_we        = 1'b1;
                            n_count       = r_count + 1'b1;
                            n_out_verdict = VERDICT_DEFERRED;
                        end else begin
                            n_out_verdict = VERDICT_REFUSED;
                        end
                    end else if (r_rate != '0) begin
                        n_bal   = (bal_sum > {1'b0, r_rate}) ? r_rate
                                                             : bal_sum[RATE_W-1:0];
                        n_nrel  = '0;
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                // a release is held back in a pending register so its last flag is known
                if (head_fits) begin
                    if (!r_pend_valid || out_free) begin
                        if (r_pend_valid) begin
                            n_out_valid   = 1'b1;
                            n_out_tag     = r_pend_tag;
                            n_out_len     = r_pend_len;
                            n_out_verdict = VERDICT_RELEASED;
                            n_out_last    = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_len   = r_rd_len;
                        n_pend_tag   = r_rd_tag;
                        n_bal        = r_bal - r_rd_len;
                        n_head       = head_inc;
                        n_count      = r_count - 1'b1;
                        n_nrel       = r_nrel + 1'b1;
                    end
                end else if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_tag     = r_pend_tag;
                    n_out_len     = r_pend_len;
                    n_out_verdict = VERDICT_RELEASED;
                    n_out_last    = 1'b1;
                    n_pend_valid  = 1'b0;
                    n_state       = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_rate       <= '0;
            r_bal        <= '0;
            r_head       <= '0;
            r_count      <= '0;
            r_nrel       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rate       <= n_rate;
            r_bal        <= n_bal;
            r_head       <= n_head;
            r_count      <= n_count;
            r_nrel       <= n_nrel;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_len    <= n_pend_len;
        r_pend_tag    <= n_pend_tag;
        r_out_tag     <= n_out_tag;
        r_out_len     <= n_out_len;
        r_out_verdict <= n_out_verdict;
        r_out_last    <= n_out_last;
    end

    // deferred queue storage; read follows the next head so data is ready
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_len[tail] <= i_item.len;
            mem_tag[tail] <= i_item.tag;
        end
        r_rd_len <= mem_len[n_head];
        r_rd_tag <= mem_tag[n_head];
    end

    assign o_out_valid = r_out_valid;
    assign o_tag       = r_out_tag;
    assign o_length    = r_out_len;
    assign o_verdict   = r_out_verdict;
    assign o_last      = r_out_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QC_W'(QUEUE_DEPTH))
        else $error("deferred queue count above depth");

    a_nrel_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nrel <= RC_W'(MAX_RESULTS))
        else $error("drain released more than the per-tick bound");

    a_pend_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_state == ST_DRAIN))
        else $error("held release outside drain");

    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_verdict != VERDICT_RELEASED)) |-> r_out_last)
        else $error("request verdict without last");

    a_release_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN && head_fits && !r_pend_valid)
            |=> (r_count == $past(r_count) - 1'b1))
        else $error("release did not pop the deferred queue");
`endif

endmodule

// File: rtl/core/io_token_bucket_shaper_top.sv
// ----------------------------------------------------------------------------
// io_token_bucket_shaper_top
// Byte-rate shaper: token bucket with a queue of deferred transfer requests.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  in       | in        | i_in_valid/o_in_stall  | kind, request_len, request_tag
//  out      | out       | o_out_valid/i_out_stall| tag, length, verdict, last
//  cfg      | in        | i_cfg_valid/o_cfg_ready| rate (32 bit)
//
//  Verdict words are registered after the intake queue; the bucket logic takes
//  one request per cycle while the output is free and no rate write or tick
//  drain is on. A nonzero-rate tick holds it in drain while covered entries are
//  released. A rate write latches the refill amount by a reciprocal multiply;
//  words wait in the intake queue for that cycle. Reset is synchronous, no clear
//  pass. Output stalls hold the result word; the intake keeps filling meanwhile.
// ----------------------------------------------------------------------------
module io_token_bucket_shaper_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [iotbs_pkg::RATE_W-1:0]     i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_kind,
    input  logic [iotbs_pkg::LEN_W-1:0]      i_request_len,
    input  logic [iotbs_pkg::TAG_BITS-1:0]   i_request_tag,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [iotbs_pkg::TAG_BITS-1:0]   o_tag,
    output logic [iotbs_pkg::LEN_W-1:0]      o_length,
    output logic [1:0]                       o_verdict,
    output logic                             o_last
);
    import iotbs_pkg::*;

    t_item  in_item;
    t_item  q_item;
    logic   q_valid;
    logic   q_pop;

    assign o_cfg_ready  = 1'b1;
    assign in_item.kind = i_kind;
    assign in_item.len  = i_request_len;
    assign in_item.tag  = i_request_tag;

    iotbs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_item       (in_item),
        .o_item_valid (q_valid),
        .o_item       (q_item),
        .i_pop        (q_pop)
    );

    iotbs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (q_valid),
        .i_item       (q_item),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_tag        (o_tag),
        .o_length     (o_length),
        .o_verdict    (o_verdict),
        .o_last       (o_last)
    );

endmodule

// File: test/tb_io_token_bucket_shaper_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_io_token_bucket_shaper_top
// Self-checking bench for the token bucket shaper. A scoreboard tracks the
// bucket balance and the deferred queue, and predicts the verdict word(s) of
// every accepted request or tick. Each output word is checked in order. The
// bench runs directed corner cases first, then random traffic under three
// rate settings and three handshake idle mixes.
// ----------------------------------------------------------------------------
module tb_io_token_bucket_shaper_top;

    import iotbs_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 28;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [LEN_W-1:0]    len;
        logic [1:0]          verdict;
        logic                last;
    } t_shaper_word;

    class token_bucket_scoreboard;
        logic [RATE_W-1:0]   rate = '0;
        logic [RATE_W-1:0]   balance = '0;
        logic [LEN_W-1:0]    deferred_len [QUEUE_DEPTH];
        logic [TAG_BITS-1:0] deferred_tag [QUEUE_DEPTH];
        int unsigned         head = 0;
        int unsigned         count = 0;
        t_shaper_word        expected_words[$];
        int                  mismatches = 0;

        function void note_rate(logic [RATE_W-1:0] value);
            rate    = value;
            balance = value;
        endfunction

        function void note_item(logic kind, logic [LEN_W-1:0] len,
                                logic [TAG_BITS-1:0] tag);
            t_shaper_word      w;
            t_shaper_word      held;
            logic              have_held;
            logic [RATE_W-1:0] refill;
            logic [RATE_W:0]   sum;
            int unsigned       slot;
            int                n;
            have_held = 1'b0;
            n = 0;
            if (kind == KIND_REQ) begin
                w.tag  = tag;
                w.len  = len;
                w.last = 1'b1;
                if (rate == '0) begin
                    w.verdict = VERDICT_GRANTED;
                end else if (balance >= len) begin
                    balance   = balance - len;
                    w.verdict = VERDICT_GRANTED;
                end else if (count < QUEUE_DEPTH) begin
                    slot = (head + count) % QUEUE_DEPTH;
                    deferred_len[slot] = len;
                    deferred_tag[slot] = tag;
                    count++;
                    w.verdict = VERDICT_DEFERRED;
                end else begin
                    w.verdict = VERDICT_REFUSED;
                end
                expected_words.push_back(w);
                return;
            end
            // tick: no effect at all while unlimited
            if (rate == '0)
                return;
            refill = rate / REFILL_DIVISOR;
            if (refill == '0)
                refill = 1;
            sum = {1'b0, balance} + {1'b0, refill};
            if (sum > {1'b0, rate})
                sum = {1'b0, rate};
            balance = sum[RATE_W-1:0];
            // release from the head while covered; the last word is only known at the end
            while (count > 0 && n < MAX_RESULTS && balance >= deferred_len[head]) begin
                balance = balance - deferred_len[head];
                if (have_held)
                    expected_words.push_back(held);
                held.tag     = deferred_tag[head];
                held.len     = deferred_len[head];
                held.verdict = VERDICT_RELEASED;
                held.last    = 1'b0;
                have_held    = 1'b1;
                head = (head + 1) % QUEUE_DEPTH;
                count--;
                n++;
            end
            if (have_held) begin
                held.last = 1'b1;
                expected_words.push_back(held);
            end
        endfunction

        function void check_word(t_shaper_word got);
            t_shaper_word exp_w;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: tag %0d len %0d verdict %0d last %0d",
                             got.tag, got.len, got.verdict, got.last);
                return;
            end
            exp_w = expected_words.pop_front();
            if (got.tag !== exp_w.tag || got.len !== exp_w.len ||
                got.verdict !== exp_w.verdict || got.last !== exp_w.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected tag %0d len %0d verdict %0d last %0d",
                             exp_w.tag, exp_w.len, exp_w.verdict, exp_w.last);
                    $display("          got tag %0d len %0d verdict %0d last %0d",
                             got.tag, got.len, got.verdict, got.last);
                end
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [RATE_W-1:0]   i_cfg_data;
    logic                i_in_valid;
    logic                o_in_stall;
    logic                i_kind;
    logic [LEN_W-1:0]    i_request_len;
    logic [TAG_BITS-1:0] i_request_tag;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [TAG_BITS-1:0] o_tag;
    logic [LEN_W-1:0]    o_length;
    logic [1:0]          o_verdict;
    logic                o_last;

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;

    token_bucket_scoreboard bucket = new();

    io_token_bucket_shaper_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_kind        (i_kind),
        .i_request_len (i_request_len),
        .i_request_tag (i_request_tag),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_tag         (o_tag),
        .o_length      (o_length),
        .o_verdict     (o_verdict),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb_io_token_bucket_shaper_top: errors");
        $finish;
    end

    // output side: stall chosen at the falling edge, word taken at the rising edge
    initial begin
        forever begin
            @(negedge i_clk);
            i_out_stall = ($urandom_range(0, 99) < recv_stall_pct);
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
                bucket.check_word({o_tag, o_length, o_verdict, o_last});
        end
    end

    // entered and left at a falling edge
    task automatic send_item(input logic kind, input logic [LEN_W-1:0] len,
                             input logic [TAG_BITS-1:0] tag);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_kind        = kind;
        i_request_len = len;
        i_request_tag = tag;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        bucket.note_item(kind, len, tag);
        @(negedge i_clk);
    endtask

    // a tick may release nothing, so give the block time to finish after the last word
    task automatic wait_idle;
        i_in_valid = 1'b0;
        while (bucket.expected_words.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_rate(input logic [RATE_W-1:0] value);
        wait_idle();
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        bucket.note_rate(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // opens with a tick so a freshly filled bucket drains what is queued
    task automatic run_traffic(input logic [RATE_W-1:0] rate, input int full_len_pct);
        logic             kind;
        logic [LEN_W-1:0] len;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            kind = (i == 0 || $urandom_range(0, 99) < 25) ? KIND_TICK : KIND_REQ;
            if ($urandom_range(0, 99) < full_len_pct)
                len = $urandom;
            else if ($urandom_range(0, 99) < 10)
                len = '0;
            else
                len = $urandom_range(rate / 8 + 2, 0);
            send_item(kind, len, $urandom_range(0, 255));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_kind        = KIND_REQ;
        i_request_len = '0;
        i_request_tag = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_gap_pct   = 35;
        recv_stall_pct = 54;

        // unlimited after reset: everything granted, ticks silent
        send_item(KIND_REQ, 32'h0000_0000, 8'h00);
        send_item(KIND_REQ, 32'hFFFF_FFFF, 8'hFF);
        send_item(KIND_TICK, 32'hFFFF_FFFF, 8'hFF);

        // rate 1000: refill of 10 per tick
        write_rate(32'd1000);
        send_item(KIND_REQ, 32'd1000, 8'd1);
        send_item(KIND_REQ, 32'd25, 8'd2);
        send_item(KIND_REQ, 32'd0, 8'd3);       // overtakes the queued word
        send_item(KIND_TICK, 32'd0, 8'd0);
        send_item(KIND_TICK, 32'd0, 8'd0);
        send_item(KIND_TICK, 32'd0, 8'd0);      // head now covered: released
        send_item(KIND_TICK, 32'd0, 8'd0);      // queue empty: no word
        send_item(KIND_REQ, 32'd40, 8'd4);
        send_item(KIND_REQ, 32'd5, 8'd5);
        send_item(KIND_TICK, 32'd0, 8'd0);

        // back to unlimited with an entry still queued
        write_rate(32'd0);
        send_item(KIND_TICK, 32'd0, 8'd0);
        send_item(KIND_REQ, 32'd7, 8'd7);

        // tiny rate: refill of one, queue fills up and starts refusing
        write_rate($urandom_range(60, 1));
        run_traffic(bucket.rate, 0);

        send_gap_pct   = 54;
        recv_stall_pct = 35;
        write_rate($urandom_range(100000, 1000));
        run_traffic(bucket.rate, 0);

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        write_rate(32'hFFFF_FFFF);
        run_traffic(bucket.rate, 10);

        wait_idle();
        if (bucket.mismatches == 0 && bucket.expected_words.size() == 0) begin
            $display("tb_io_token_bucket_shaper_top: clean");
        end else begin
            $display("tb_io_token_bucket_shaper_top: errors");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/iotbs_pkg.sv
rtl/core/iotbs_front.sv
rtl/core/iotbs_div.sv
rtl/core/iotbs_back.sv
rtl/core/io_token_bucket_shaper_top.sv
test/tb_io_token_bucket_shaper_top.sv
